// ----- hdl/bbmem_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Banked byte memory package
// Shared sizes, access codes and status codes for the banked byte memory.
// ----------------------------------------------------------------------------
package bbmem_pkg;

  localparam int unsigned CHIP_BYTES_DEF = 4096;
  localparam int unsigned MAX_CHIPS_DEF  = 4;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned LANES    = DATA_W / 8;
  localparam int unsigned CHIPS_W  = 3;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_HALF  = 2'd1,
    SIZE_WORD  = 2'd2,
    SIZE_DWORD = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_MISALIGN  = 2'd2,
    ST_UNUSED    = 2'd3
  } status_e;

  // Low-byte mask for an access of the given size.
  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
    logic [DATA_W-1:0] m;
    unique case (size)
      SIZE_BYTE:  m = 64'h0000_0000_0000_00FF;
      SIZE_HALF:  m = 64'h0000_0000_0000_FFFF;
      SIZE_WORD:  m = 64'h0000_0000_FFFF_FFFF;
      default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage : bbmem_pkg
`default_nettype wire

// ----- hdl/banked_byte_memory_aligned_access.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Banked byte memory, aligned big-endian access
// Byte-addressed RAM of MAX_CHIPS chips, one 64-bit word per row.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: an item is taken at a rising edge with start_i high and
//    busy_o low. busy_o stays low, so an item may be issued every cycle.
//  - Each item gives one result: done_o is high for exactly one cycle, the
//    cycle after the item was taken, with read_data_o and status_o valid.
//    The receiver cannot stall; results must be sampled in that cycle.
//  - Throughput 1 item per cycle, set by the single RAM
//    port: a write lands in the RAM at the accepting edge, a read is
//    registered at that edge and aligned in the following cycle.
//  - Configuration: chips_in_use_i is written on cfg_valid_i (cfg_ready_o is
//    always high). Write it only while no result is pending.
//  - Reset: chips_in_use returns to 1, no result pending. RAM contents are
//    not cleared; a byte must be written before it is read.
//  - Values are big-endian: the byte at the lowest address sits in the most
//    significant lane of the row (bits 63:56 hold byte offset 0).
// ----------------------------------------------------------------------------
module banked_byte_memory_aligned_access
  import bbmem_pkg::*;
#(
  parameter int unsigned CHIP_BYTES = CHIP_BYTES_DEF,
  parameter int unsigned MAX_CHIPS  = MAX_CHIPS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              func_i,
  input  wire logic [1:0]        access_size_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  // result channel
  output logic                   done_o,
  output logic [DATA_W-1:0]      read_data_o,
  output logic [1:0]             status_o,
  // configuration channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CHIPS_W-1:0] chips_in_use_i
);

  localparam int unsigned STORE_BYTES = CHIP_BYTES * MAX_CHIPS;
  localparam int unsigned DEPTH       = STORE_BYTES / LANES;
  localparam int unsigned IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [CHIPS_W-1:0] chips_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chips_q <= CHIPS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      chips_q <= chips_in_use_i;
    end
  end

  // --------------------------------------------------------------------------
  // Request decode: range and alignment check, lane placement
  // --------------------------------------------------------------------------
  logic              accept;
  logic [31:0]       chips_eff;
  logic [31:0]       limit;
  logic [31:0]       end_addr;
  logic [3:0]        nbytes;
  logic              misaligned;
  logic [1:0]        status_d;
  logic [3:0]        shift_full;
  logic [2:0]        shift_d;
  logic [IDX_W-1:0]  row_idx;
  logic [DATA_W-1:0] wdata_lanes;
  logic [LANES-1:0]  byte_en;
  logic              wr_en;

  assign accept = start_i && !busy_o;

  always_comb begin
    // clamp fitted chips to what is built
    if (32'(chips_q) > MAX_CHIPS) chips_eff = MAX_CHIPS;
    else                          chips_eff = 32'(chips_q);
    limit    = chips_eff * CHIP_BYTES;
    nbytes   = 4'd1 << access_size_i;
    end_addr = 32'(address_i) + 32'(nbytes);

    unique case (access_size_i)
      SIZE_BYTE: misaligned = 1'b0;
      SIZE_HALF: misaligned = address_i[0];
      SIZE_WORD: misaligned = |address_i[1:0];
      default:   misaligned = |address_i[2:0];
    endcase

    priority if (end_addr > limit) status_d = ST_RANGE;
    else if (misaligned)           status_d = ST_MISALIGN;
    else                           status_d = ST_OK;

    // bytes of the row below the last byte accessed
    shift_full = 4'd8 - {1'b0, address_i[2:0]} - nbytes;
    shift_d    = shift_full[2:0];

    row_idx     = IDX_W'(32'(address_i) >> 3);
    wdata_lanes = (write_data_i & size_mask(access_size_i)) << {shift_d, 3'b000};
    byte_en     = LANES'(((9'd1 << nbytes) - 9'd1) << shift_d);
    wr_en       = accept && (func_i == FUNC_WRITE) && (status_d == ST_OK);
  end

  // --------------------------------------------------------------------------
  // RAM: one port, byte-enabled write, registered read
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_word_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int k = 0; k < LANES; k++) begin
        if (byte_en[k]) mem_q[row_idx][8*k +: 8] <= wdata_lanes[8*k +: 8];
      end
    end
    if (accept) rd_word_q <= mem_q[row_idx];
  end

  // --------------------------------------------------------------------------
  // Result stage
  // --------------------------------------------------------------------------
  logic       done_q;
  logic       is_read_q;
  logic [1:0] size_q;
  logic [2:0] shift_q;
  logic [1:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_read_q <= (func_i == FUNC_READ);
      size_q    <= access_size_i;
      shift_q   <= shift_d;
      status_q  <= status_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;

  always_comb begin
    if (is_read_q && (status_q == ST_OK)) begin
      read_data_o = (rd_word_q >> {shift_q, 3'b000}) & size_mask(size_q);
    end else begin
      read_data_o = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result without a taken item");

  a_accept_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("taken item gave no result");

  a_fail_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (read_data_o == '0))
    else $error("failed access returned data");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(func_i == FUNC_WRITE)) |-> (read_data_o == '0))
    else $error("write returned data");

endmodule : banked_byte_memory_aligned_access
`default_nettype wire

// ----- test/tb_banked_byte_memory_aligned_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: banked byte memory, aligned big-endian access
// Drives reads and writes of every size across several chip counts and checks
// each result against an in-bench memory image that follows the same rules.
// ----------------------------------------------------------------------------
module tb_banked_byte_memory_aligned_access;
  import bbmem_pkg::*;

  localparam int unsigned STORE_BYTES = CHIP_BYTES_DEF * MAX_CHIPS_DEF;
  localparam int unsigned HOT_BYTES   = 512;

  // One entry of the stimulus list: either a memory access or a chip count.
  typedef struct packed {
    logic              is_cfg;
    logic [CHIPS_W-1:0] chips;
    func_e             func;
    size_e             size;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  // What the memory should answer for one access.
  typedef struct packed {
    logic              is_read;
    logic [DATA_W-1:0] rdata;
    status_e           status;
  } mem_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start_i        = 1'b0;
  logic              func_i         = 1'b0;
  logic [1:0]        access_size_i  = '0;
  logic [ADDR_W-1:0] address_i      = '0;
  logic [DATA_W-1:0] write_data_i   = '0;
  logic              cfg_valid_i    = 1'b0;
  logic [CHIPS_W-1:0] chips_in_use_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [DATA_W-1:0] read_data_o;
  logic [1:0]        status_o;
  logic              cfg_ready_o;

  always #10 clk_i = ~clk_i;

  banked_byte_memory_aligned_access uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .access_size_i  (access_size_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .chips_in_use_i (chips_in_use_i)
  );

  // --------------------------------------------------------------------------
  // Shared state
  // --------------------------------------------------------------------------
  mem_req_t    pend_q[$];      // items and chip counts still to be driven
  mem_result_t expected_q[$];  // answers owed by the block, oldest first

  // Checker's own memory image and chip count, updated on accepted handshakes.
  logic [7:0]         image_mem [0:STORE_BYTES-1];
  logic [CHIPS_W-1:0] image_chips = 3'd1;

  // Generator bookkeeping: which bytes will have been written by the time an
  // item reaches the block. Reads that would succeed are only built over
  // bytes marked here, so the undefined RAM contents are never observed.
  bit                 gen_written [0:STORE_BYTES-1];
  int unsigned        gen_addr_q[$];
  logic [CHIPS_W-1:0] gen_chips = 3'd1;

  logic cmd_taken = 1'b0;   // start_i was accepted at the last rising edge
  logic cfg_taken = 1'b0;   // chip count was written at the last rising edge

  int unsigned n_errors   = 0;
  int unsigned n_issued   = 0;
  int unsigned n_reads    = 0;
  int unsigned n_writes   = 0;
  int unsigned n_range    = 0;
  int unsigned n_misalign = 0;
  int unsigned n_settings = 0;

  // Top valid byte address plus one; counts above the fitted maximum clamp.
  function automatic int unsigned top_of(logic [CHIPS_W-1:0] chips);
    int unsigned fitted;
    fitted = (chips > MAX_CHIPS_DEF) ? MAX_CHIPS_DEF : chips;
    return fitted * CHIP_BYTES_DEF;
  endfunction

  // Range check first, then alignment; shared by generator and checker.
  function automatic status_e access_status(int unsigned addr, int unsigned nbytes,
                                            logic [CHIPS_W-1:0] chips);
    if (addr + nbytes > top_of(chips)) return ST_RANGE;
    if (addr % nbytes != 0) return ST_MISALIGN;
    return ST_OK;
  endfunction

  // Applies one access to the image and returns the answer it should give.
  // Big-endian: the lowest address carries the most significant byte.
  function automatic mem_result_t big_endian_access(mem_req_t r);
    mem_result_t res;
    int unsigned nbytes;
    int unsigned i;
    nbytes      = 32'd1 << r.size;
    res.is_read = (r.func == FUNC_READ);
    res.rdata   = '0;
    res.status  = access_status(r.addr, nbytes, image_chips);
    if (res.status == ST_OK) begin
      for (i = 0; i < nbytes; i++) begin
        if (r.func == FUNC_WRITE) begin
          image_mem[r.addr + i] = r.wdata[8 * (nbytes - 1 - i) +: 8];
        end else begin
          res.rdata = {res.rdata[DATA_W-9:0], image_mem[r.addr + i]};
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus list builders
  // --------------------------------------------------------------------------
  task automatic queue_chips(logic [CHIPS_W-1:0] chips);
    mem_req_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.chips  = chips;
    gen_chips = chips;
    pend_q.push_back(r);
  endtask

  // A read that would succeed over a byte never written turns into a write;
  // successful writes mark their bytes for later reads.
  task automatic queue_access(func_e func, size_e size, int unsigned addr,
                              logic [DATA_W-1:0] wdata);
    mem_req_t    r;
    int unsigned nbytes;
    int unsigned i;
    bit          all_set;
    nbytes = 32'd1 << size;
    if (access_status(addr[ADDR_W-1:0], nbytes, gen_chips) == ST_OK) begin
      all_set = 1'b1;
      for (i = 0; i < nbytes; i++) all_set &= gen_written[addr + i];
      if (func == FUNC_READ && !all_set) func = FUNC_WRITE;
      if (func == FUNC_WRITE) begin
        for (i = 0; i < nbytes; i++) begin
          if (!gen_written[addr + i]) gen_addr_q.push_back(addr + i);
          gen_written[addr + i] = 1'b1;
        end
      end
    end
    r        = '0;
    r.func   = func;
    r.size   = size;
    r.addr   = addr[ADDR_W-1:0];
    r.wdata  = wdata;
    pend_q.push_back(r);
  endtask

  // Mostly aligned in-range writes and reads of written data, clustered in
  // the low part of each chip so reads see overwritten bytes; the rest is
  // noise: any address, accesses straddling the top, misaligned offsets.
  task automatic queue_random(int unsigned count);
    int unsigned k, n, lim, nbytes, addr, fitted;
    size_e       size;
    func_e       func;
    for (n = 0; n < count; n++) begin
      k      = $urandom_range(99);
      size   = size_e'($urandom_range(3));
      nbytes = 32'd1 << size;
      lim    = top_of(gen_chips);
      fitted = lim / CHIP_BYTES_DEF;
      func   = func_e'($urandom_range(1));
      if (k < 45 && lim > 0) begin
        if ($urandom_range(9) < 7)
          addr = $urandom_range(fitted - 1) * CHIP_BYTES_DEF + $urandom_range(HOT_BYTES - 1);
        else
          addr = $urandom_range(lim - 1);
        addr = addr - addr % nbytes;
        func = FUNC_WRITE;
      end else if (k < 80 && gen_addr_q.size() > 0) begin
        addr = gen_addr_q[$urandom_range(gen_addr_q.size() - 1)];
        addr = addr - addr % nbytes;
        // widen only where every byte of the span is known; else one byte
        for (int i = 0; i < nbytes; i++) begin
          if (!gen_written[addr + i]) begin
            size = SIZE_BYTE;
            addr = gen_addr_q[$urandom_range(gen_addr_q.size() - 1)];
            break;
          end
        end
        func = FUNC_READ;
      end else begin
        case ($urandom_range(2))
          0:       addr = $urandom_range(16'hFFFF);
          1:       addr = (lim - $urandom_range(1, 8)) & 16'hFFFF;
          default: addr = ($urandom_range(HOT_BYTES - 1) & ~32'h7) + $urandom_range(7);
        endcase
      end
      queue_access(func, size, addr, {$urandom, $urandom});
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. An item is held until the
  // rising edge that takes it; a chip count goes out only with nothing owed.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    mem_req_t req;
    logic     hold_cmd;
    logic     hold_cfg;
    logic     no_idle;
    hold_cmd = start_i && !cmd_taken;
    hold_cfg = cfg_valid_i && !cfg_taken;
    no_idle  = (n_issued >= 200 && n_issued < 320);
    if (rst_ni && !hold_cmd && !hold_cfg && pend_q.size() > 0) begin
      req = pend_q[0];
      if (req.is_cfg) begin
        if (expected_q.size() == 0) begin
          void'(pend_q.pop_front());
          chips_in_use_i <= req.chips;
          hold_cfg = 1'b1;
        end
      end else if (no_idle || $urandom_range(99) >= 18) begin
        void'(pend_q.pop_front());
        func_i        <= req.func;
        access_size_i <= req.size;
        address_i     <= req.addr;
        write_data_i  <= req.wdata;
        hold_cmd = 1'b1;
        n_issued++;
      end
    end
    // junk on the idle bus, which the block must ignore
    if (!hold_cmd) begin
      address_i    <= 16'($urandom);
      write_data_i <= {$urandom, $urandom};
    end
    start_i     <= hold_cmd;
    cfg_valid_i <= hold_cfg;
  end

  // --------------------------------------------------------------------------
  // Monitor and checker, on the rising edge. The result of an item comes in the
  // cycle after it is taken, so the pop below never meets the push that
  // follows it in the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    mem_result_t exp_res;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item pending: read_data %h status %0d",
                   $time, read_data_o, status_o);
          n_errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (read_data_o !== exp_res.rdata) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, exp_res.rdata, read_data_o);
            n_errors++;
          end
          if (status_o !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_res.status, status_o);
            n_errors++;
          end
          case (exp_res.status)
            ST_RANGE:    n_range++;
            ST_MISALIGN: n_misalign++;
            default:     if (exp_res.is_read) n_reads++; else n_writes++;
          endcase
        end
      end
      if (start_i && !busy_o) begin
        expected_q.push_back(big_endian_access('{is_cfg: 1'b0, chips: '0,
            func: func_e'(func_i), size: size_e'(access_size_i),
            addr: address_i, wdata: write_data_i}));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        image_chips = chips_in_use_i;
        n_settings++;
      end
    end
    cmd_taken <= rst_ni && start_i && !busy_o;
    cfg_taken <= rst_ni && cfg_valid_i && cfg_ready_o;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    logic [CHIPS_W-1:0] chip_plan[$];
    chip_plan = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd1, 3'd6, 3'd4};

    // Directed, under the reset chip count of one (top address 4095).
    // Upper write data bytes carry junk to show they are dropped.
    queue_access(FUNC_WRITE, SIZE_BYTE,  0,  64'hFFFF_FFFF_FFFF_FFA5);
    queue_access(FUNC_WRITE, SIZE_BYTE,  1,  64'h0000_0000_0000_003C);
    queue_access(FUNC_WRITE, SIZE_HALF,  2,  64'h1234_5678_9ABC_BEEF);
    queue_access(FUNC_WRITE, SIZE_WORD,  4,  64'hDEAD_0000_1234_5678);
    queue_access(FUNC_WRITE, SIZE_DWORD, 8,  64'h0123_4567_89AB_CDEF);
    queue_access(FUNC_READ,  SIZE_DWORD, 0,  '0);  // stitches the first four writes
    queue_access(FUNC_READ,  SIZE_BYTE,  1,  '1);
    queue_access(FUNC_READ,  SIZE_HALF,  2,  '0);
    queue_access(FUNC_READ,  SIZE_WORD,  4,  '0);
    queue_access(FUNC_READ,  SIZE_DWORD, 8,  '0);
    queue_access(FUNC_READ,  SIZE_BYTE,  15, '0);
    queue_access(FUNC_WRITE, SIZE_DWORD, 16, '1);
    queue_access(FUNC_WRITE, SIZE_DWORD, 24, '0);
    queue_access(FUNC_READ,  SIZE_DWORD, 16, '0);
    queue_access(FUNC_READ,  SIZE_DWORD, 24, '0);
    // last doubleword, last word and last byte below the top
    queue_access(FUNC_WRITE, SIZE_DWORD, 4088, 64'h8000_0000_0000_0001);
    queue_access(FUNC_READ,  SIZE_DWORD, 4088, '0);
    queue_access(FUNC_WRITE, SIZE_WORD,  4092, '1);
    queue_access(FUNC_WRITE, SIZE_BYTE,  4095, 64'h7E);
    queue_access(FUNC_READ,  SIZE_WORD,  4092, '0);
    // crossing the top, past it, and misaligned; range wins over alignment
    queue_access(FUNC_WRITE, SIZE_WORD,  4094, '1);
    queue_access(FUNC_READ,  SIZE_HALF,  4096, '0);
    queue_access(FUNC_WRITE, SIZE_HALF,  1,    '1);
    queue_access(FUNC_READ,  SIZE_WORD,  2,    '0);
    queue_access(FUNC_READ,  SIZE_DWORD, 4,    '0);
    queue_access(FUNC_READ,  SIZE_BYTE,  16'hFFFF, '0);
    queue_access(FUNC_WRITE, SIZE_DWORD, 16'hFFF8, '1);

    queue_random(60);
    foreach (chip_plan[p]) begin
      queue_chips(chip_plan[p]);
      // with no chips fitted every access fails, so keep that phase short
      queue_random(chip_plan[p] == 3'd0 ? 20 : 60);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() > 0 || start_i || cfg_valid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (expected_q.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      n_errors += expected_q.size();
    end

    $display("Ran %0d accesses over %0d chip counts: %0d reads, %0d writes done,",
             n_issued, n_settings + 1, n_reads, n_writes);
    $display("  %0d out of range, %0d misaligned, %0d errors",
             n_range, n_misalign, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: ends the run if the traffic never drains.
  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
